/* sv/sctc_pkg.sv */
// Shared widths, request mode codes and limits for the sector cache
// tag controller. No dependencies.

package sctc_pkg;

   localparam int MODE_W      = 2;
   localparam int SECTOR_W    = 32;
   localparam int TIME_W      = 32;
   localparam int SLOT_W      = 6;
   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [SECTOR_W-1:0] sector_type;
   typedef logic [TIME_W-1:0]   time_type;

   localparam mode_type MODE_READ  = 2'd0;
   localparam mode_type MODE_WRITE = 2'd1;
   localparam mode_type MODE_FLUSH = 2'd2;

endpackage

/* sv/sector_cache_lru_tag_controller_core.sv */
// Tag and LRU replacement controller of a fully associative write-back
// sector cache. Depends on sctc_pkg.
//
//   channel  ports                                                   dir
//   request  req_valid req_ready req_mode req_sector req_access_time in
//   response rsp_valid rsp_ready rsp_hit rsp_slot rsp_fill_needed    out
//            rsp_writeback_valid rsp_writeback_sector rsp_last
//
// After a read or write request is accepted, one shared compare stage
// walks the tag and time memories one entry a cycle.
// A flush walks the valid/dirty flags one entry a cycle while no dirty entry
// holds it; each dirty entry takes an extra tag-read state, which can stall.
// Reset is synchronous and clears all valid and dirty flags at once; the tag
// and time memories need no clearing. A full result register with rsp_ready
// low stalls the flush walk; no request is taken until the current one ends.

module sector_cache_lru_tag_controller_core
   import sctc_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [TIME_W-1:0]   req_access_time,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_fill_needed,
   output logic                rsp_writeback_valid,
   output logic [SECTOR_W-1:0] rsp_writeback_sector,
   output logic                rsp_last
);

   localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W  = $clog2(ENTRIES + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_AC_SCAN = 3'd1;
   localparam logic [2:0] ST_AC_DONE = 3'd2;
   localparam logic [2:0] ST_FL_SCAN = 3'd3;
   localparam logic [2:0] ST_FL_TAG  = 3'd4;
   localparam logic [2:0] ST_FL_END  = 3'd5;

   // tag and last-use stores
   sector_type tag_mem  [ENTRIES];
   time_type   time_mem [ENTRIES];

   logic [2:0]         state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] dirty_ff, dirty_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic               hit_found_ff, hit_found_in;
   logic [ADDR_W-1:0]  hit_slot_ff, hit_slot_in;
   logic               free_found_ff, free_found_in;
   logic [ADDR_W-1:0]  free_slot_ff, free_slot_in;
   time_type           best_time_ff, best_time_in;
   logic [ADDR_W-1:0]  best_slot_ff, best_slot_in;
   sector_type         best_tag_ff, best_tag_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_slot_ff, pend_slot_in;
   sector_type         pend_tag_ff, pend_tag_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               is_write_ff, is_write_in;
   sector_type         sector_ff, sector_in;
   time_type           atime_ff, atime_in;

   logic               out_vld_ff, out_vld_in;
   logic               out_hit_ff, out_hit_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic               out_fill_ff, out_fill_in;
   logic               out_wbv_ff, out_wbv_in;
   sector_type         out_wbs_ff, out_wbs_in;
   logic               out_last_ff, out_last_in;

   sector_type         tag_q_ff;
   time_type           time_q_ff;

   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we;
   logic               tag_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic               out_free;
   logic               idx_end;
   logic               flagged;
   logic [ADDR_W-1:0]  dec_slot;
   logic               dec_fill;
   logic               dec_wbv;
   sector_type         dec_wbs;

   assign rd_addr   = idx_ff[ADDR_W-1:0];
   assign out_free  = !out_vld_ff || rsp_ready;
   assign idx_end   = (idx_ff == IDX_W'(ENTRIES));
   assign flagged   = valid_ff[rd_addr] && dirty_ff[rd_addr];
   assign req_ready = (state_ff == ST_IDLE);

   // miss handling: free entry first, else the least recently used one
   always_comb begin
      dec_slot = best_slot_ff;
      dec_fill = 1'b1;
      dec_wbv  = 1'b0;
      dec_wbs  = '0;
      priority if (hit_found_ff) begin
         dec_slot = hit_slot_ff;
         dec_fill = 1'b0;
      end else if (free_found_ff) begin
         dec_slot = free_slot_ff;
      end else if (dirty_ff[best_slot_ff]) begin
         dec_wbv = 1'b1;
         dec_wbs = best_tag_ff;
      end else begin
         dec_wbv = 1'b0;
      end
   end

   assign mem_we  = (state_ff == ST_AC_DONE) && out_free;
   assign tag_we  = mem_we && !hit_found_ff;
   assign wr_addr = dec_slot;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      best_time_in  = best_time_ff;
      best_slot_in  = best_slot_ff;
      best_tag_in   = best_tag_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      cnt_in        = cnt_ff;
      is_write_in   = is_write_ff;
      sector_in     = sector_ff;
      atime_in      = atime_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;
      out_hit_in    = out_hit_ff;
      out_slot_in   = out_slot_ff;
      out_fill_in   = out_fill_ff;
      out_wbv_in    = out_wbv_ff;
      out_wbs_in    = out_wbs_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               pend_in       = 1'b0;
               cnt_in        = '0;
               is_write_in   = (req_mode == MODE_WRITE);
               sector_in     = req_sector;
               atime_in      = req_access_time;
               priority if (req_mode == MODE_READ || req_mode == MODE_WRITE) begin
                  state_in = ST_AC_SCAN;
               end else if (req_mode == MODE_FLUSH) begin
                  state_in = ST_FL_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_AC_SCAN: begin
            // issue the next read while comparing the previous entry
            if (!idx_end) begin
               idx_in     = idx_ff + IDX_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_addr;
            end
            if (cmp_vld_ff) begin
               if (!hit_found_ff && valid_ff[cmp_idx_ff] && tag_q_ff == sector_ff) begin
                  hit_found_in = 1'b1;
                  hit_slot_in  = cmp_idx_ff;
               end
               if (!free_found_ff && !valid_ff[cmp_idx_ff]) begin
                  free_found_in = 1'b1;
                  free_slot_in  = cmp_idx_ff;
               end
               if (cmp_idx_ff == '0 || time_q_ff < best_time_ff) begin
                  best_time_in = time_q_ff;
                  best_slot_in = cmp_idx_ff;
                  best_tag_in  = tag_q_ff;
               end
               if (cmp_idx_ff == ADDR_W'(ENTRIES - 1)) begin
                  state_in = ST_AC_DONE;
               end
            end
         end

         ST_AC_DONE: begin
            if (out_free) begin
               valid_in[dec_slot] = 1'b1;
               if (is_write_ff) begin
                  dirty_in[dec_slot] = 1'b1;
               end else if (!hit_found_ff) begin
                  dirty_in[dec_slot] = 1'b0;
               end
               out_vld_in  = 1'b1;
               out_hit_in  = hit_found_ff;
               out_slot_in = SLOT_W'(dec_slot);
               out_fill_in = dec_fill;
               out_wbv_in  = dec_wbv;
               out_wbs_in  = dec_wbs;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         ST_FL_SCAN: begin
            priority if (idx_end || cnt_ff == CNT_W'(MAX_RESULTS)) begin
               state_in = ST_FL_END;
            end else if (flagged) begin
               state_in = ST_FL_TAG;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_FL_TAG: begin
            // hold one writeback back so the final one can carry last
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  out_vld_in  = 1'b1;
                  out_hit_in  = 1'b0;
                  out_slot_in = SLOT_W'(pend_slot_ff);
                  out_fill_in = 1'b0;
                  out_wbv_in  = 1'b1;
                  out_wbs_in  = pend_tag_ff;
                  out_last_in = 1'b0;
               end
               pend_in           = 1'b1;
               pend_slot_in      = rd_addr;
               pend_tag_in       = tag_q_ff;
               dirty_in[rd_addr] = 1'b0;
               cnt_in            = cnt_ff + CNT_W'(1);
               idx_in            = idx_ff + IDX_W'(1);
               state_in          = ST_FL_SCAN;
            end
         end

         ST_FL_END: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_hit_in  = 1'b0;
               out_fill_in = 1'b0;
               out_last_in = 1'b1;
               if (pend_ff) begin
                  out_slot_in = SLOT_W'(pend_slot_ff);
                  out_wbv_in  = 1'b1;
                  out_wbs_in  = pend_tag_ff;
               end else begin
                  out_slot_in = '0;
                  out_wbv_in  = 1'b0;
                  out_wbs_in  = '0;
               end
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         pend_ff       <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         pend_ff       <= pend_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      best_time_ff <= best_time_in;
      best_slot_ff <= best_slot_in;
      best_tag_ff  <= best_tag_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      cnt_ff       <= cnt_in;
      is_write_ff  <= is_write_in;
      sector_ff    <= sector_in;
      atime_ff     <= atime_in;
      out_hit_ff   <= out_hit_in;
      out_slot_ff  <= out_slot_in;
      out_fill_ff  <= out_fill_in;
      out_wbv_ff   <= out_wbv_in;
      out_wbs_ff   <= out_wbs_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wr_addr] <= sector_ff;
      end
      tag_q_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[wr_addr] <= atime_ff;
      end
      time_q_ff <= time_mem[rd_addr];
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_hit              = out_hit_ff;
   assign rsp_slot             = out_slot_ff;
   assign rsp_fill_needed      = out_fill_ff;
   assign rsp_writeback_valid  = out_wbv_ff;
   assign rsp_writeback_sector = out_wbs_ff;
   assign rsp_last             = out_last_ff;

endmodule
